[design/rpcc_pkg.sv]
// Shared types, constants and the sample offset table for the rotated pixel
// cell coverage block. No dependencies.
`default_nettype none

package rpcc_pkg;

  // Fixed-point formats.
  localparam int FRAC_BITS = 16;
  localparam int TRIG_BITS = 16;
  localparam int COORD_W   = 28;
  localparam int TRIG_W    = 18;
  localparam int PROD_W    = COORD_W + TRIG_W;
  localparam int OFS_W     = FRAC_BITS + 1;
  localparam int TERM_W    = OFS_W + TRIG_W + 1;
  localparam int ACC_W     = 48;
  localparam int SHIFT     = FRAC_BITS + TRIG_BITS;
  localparam int CELL_W    = 13;
  localparam int COUNT_W   = 8;

  // Sample grid size.
  localparam int RAD_W      = 3;
  localparam int MAX_RADIUS = 7;
  localparam int TAPS       = 2 * MAX_RADIUS + 1;
  localparam int TAP_W      = $clog2(TAPS);
  localparam int ISSUE_W    = $clog2(4 * MAX_RADIUS + 6);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIN    = 2'd2;

  // Multiplier issue slots ahead of the offset terms.
  localparam logic [ISSUE_W-1:0] MUL_CX_COS = ISSUE_W'(0);
  localparam logic [ISSUE_W-1:0] MUL_CY_SIN = ISSUE_W'(1);
  localparam logic [ISSUE_W-1:0] MUL_CY_COS = ISSUE_W'(2);
  localparam logic [ISSUE_W-1:0] MUL_CX_SIN = ISSUE_W'(3);
  localparam logic [ISSUE_W-1:0] MUL_TERMS  = ISSUE_W'(4);

  // One floored sample on its way into the cell table.
  typedef struct packed {
    logic                     vld;
    logic signed [CELL_W-1:0] x;
    logic signed [CELL_W-1:0] y;
  } cell_smp_t;

  // Offset magnitude (a << FRAC_BITS) / (2n), truncated, for radius n and |j| = a.
  function automatic logic [FRAC_BITS-1:0] grid_frac(input logic [RAD_W-1:0] n,
                                                     input logic [RAD_W-1:0] a);
    logic [FRAC_BITS-1:0] v;
    case ({n, a})
      6'o11: v = 16'd32768;
      6'o21: v = 16'd16384;
      6'o22: v = 16'd32768;
      6'o31: v = 16'd10922;
      6'o32: v = 16'd21845;
      6'o33: v = 16'd32768;
      6'o41: v = 16'd8192;
      6'o42: v = 16'd16384;
      6'o43: v = 16'd24576;
      6'o44: v = 16'd32768;
      6'o51: v = 16'd6553;
      6'o52: v = 16'd13107;
      6'o53: v = 16'd19660;
      6'o54: v = 16'd26214;
      6'o55: v = 16'd32768;
      6'o61: v = 16'd5461;
      6'o62: v = 16'd10922;
      6'o63: v = 16'd16384;
      6'o64: v = 16'd21845;
      6'o65: v = 16'd27306;
      6'o66: v = 16'd32768;
      6'o71: v = 16'd4681;
      6'o72: v = 16'd9362;
      6'o73: v = 16'd14043;
      6'o74: v = 16'd18724;
      6'o75: v = 16'd23405;
      6'o76: v = 16'd28086;
      6'o77: v = 16'd32768;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[design/rotated_pixel_cell_coverage.sv]
// Rotated pixel cell coverage: one shared multiplier prepares the rotated center
// and 2(2n+1) offset terms, then waits for the last product; each of the 2n+1 sample
// rows forms its row base and then steps through its samples; after a drain state the
// cells leave one by one, held by output stalls, and the block returns to idle.
// Input only while idle. Async active-low reset: radius 2, cos 1.0, sin 0, idle.
`default_nettype none

module rotated_pixel_cell_coverage
  import rpcc_pkg::*;
#(
  parameter int CELL_SLOTS = 9
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [TRIG_W-1:0]         cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic signed [COORD_W-1:0] center_x_i,
  input  wire logic signed [COORD_W-1:0] center_y_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic signed [CELL_W-1:0]       cell_x_o,
  output logic signed [CELL_W-1:0]       cell_y_o,
  output logic [COUNT_W-1:0]             sample_count_o,
  output logic                           last_o
);

  localparam int CNT_W = $clog2(CELL_SLOTS + 1);
  localparam int IDX_W = $clog2(CELL_SLOTS);
  localparam int IP_W  = ACC_W - SHIFT;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_MWAIT = 3'd2;
  localparam logic [2:0] S_ROW   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  // Saturate an integer part to the cell range.
  function automatic logic signed [CELL_W-1:0] sat_cell(input logic signed [IP_W-1:0] v);
    logic signed [CELL_W-1:0] r;
    if (v[IP_W-1:CELL_W-1] == {(IP_W-CELL_W+1){v[CELL_W-1]}}) begin
      r = v[CELL_W-1:0];
    end else if (v[IP_W-1]) begin
      r = {1'b1, {(CELL_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(CELL_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Configuration registers.
  logic [RAD_W-1:0]         radius_q;
  logic signed [TRIG_W-1:0] cos_q;
  logic signed [TRIG_W-1:0] sin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RAD_W'(2);
      cos_q    <= TRIG_W'(65536);
      sin_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RADIUS: radius_q <= cfg_data_i[RAD_W-1:0];
        REG_COS:    cos_q    <= cfg_data_i;
        REG_SIN:    sin_q    <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Sequencer state and counters.
  logic [2:0]         state_q, state_d;
  logic [ISSUE_W-1:0] mi_q, mi_d;
  logic [TAP_W-1:0]   r_q, r_d;
  logic [TAP_W-1:0]   c_q, c_d;
  logic [CNT_W-1:0]   emit_idx_q, emit_idx_d;
  logic               in_acc;
  logic               emit_load;
  logic               out_valid_q;

  // Item registers.
  logic signed [COORD_W-1:0] cx_q, cy_q;
  logic [RAD_W-1:0]          n_q;
  logic                      dis_q;
  logic [TAP_W-1:0]          two_n;
  logic [ISSUE_W-1:0]        last_issue;
  logic [FRAC_BITS+3:0]      fx10, fy10;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign two_n      = {1'b0, n_q} << 1;
  assign last_issue = (ISSUE_W'(n_q) << 2) + ISSUE_W'(5);

  // Fraction times ten, for the "below one tenth" test.
  assign fx10 = {1'b0, center_x_i[FRAC_BITS-1:0], 3'b000} +
                {3'b000, center_x_i[FRAC_BITS-1:0], 1'b0};
  assign fy10 = {1'b0, center_y_i[FRAC_BITS-1:0], 3'b000} +
                {3'b000, center_y_i[FRAC_BITS-1:0], 1'b0};

  // Capture the center, the effective radius and the half-cell shift on accept.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cx_q  <= center_x_i;
      cy_q  <= center_y_i;
      n_q   <= (radius_q == '0) ? RAD_W'(1) : radius_q;
      dis_q <= (fx10[FRAC_BITS+3:FRAC_BITS] == '0) && (fy10[FRAC_BITS+3:FRAC_BITS] == '0);
    end
  end

  // Offset of grid point j for the current item.
  logic [ISSUE_W-1:0]     mi_off;
  logic [TAP_W-1:0]       jj;
  logic [TAP_W-1:0]       nn;
  logic [TAP_W-1:0]       mag;
  logic [FRAC_BITS-1:0]   frac;
  logic signed [OFS_W-1:0] ofs;

  assign mi_off = mi_q - MUL_TERMS;
  assign jj     = mi_off[TAP_W:1];
  assign nn     = TAP_W'(n_q);
  assign mag    = (jj < nn) ? (nn - jj) : (jj - nn);
  assign frac   = grid_frac(n_q, mag[RAD_W-1:0]);

  always_comb begin
    if (jj < nn) begin
      ofs = -$signed({1'b0, frac}) + $signed(OFS_W'(jj == '0));
    end else begin
      ofs = $signed({1'b0, frac}) - $signed(OFS_W'(jj == two_n));
    end
  end

  // Operand selection for the shared multiplier.
  logic signed [COORD_W-1:0] mul_a;
  logic signed [TRIG_W-1:0]  mul_b;
  logic                      mul_vld;

  always_comb begin
    mul_a = {{(COORD_W-OFS_W){ofs[OFS_W-1]}}, ofs};
    mul_b = mi_off[0] ? sin_q : cos_q;
    case (mi_q)
      MUL_CX_COS: begin
        mul_a = cx_q;
        mul_b = cos_q;
      end
      MUL_CY_SIN: begin
        mul_a = cy_q;
        mul_b = sin_q;
      end
      MUL_CY_COS: begin
        mul_a = cy_q;
        mul_b = cos_q;
      end
      MUL_CX_SIN: begin
        mul_a = cx_q;
        mul_b = sin_q;
      end
      default: ;
    endcase
  end

  assign mul_vld = (state_q == S_SETUP);

  logic                     prod_vld;
  logic [ISSUE_W-1:0]       prod_tag;
  logic signed [PROD_W-1:0] prod;

  rpcc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (mul_vld),
    .tag_i  (mi_q),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .vld_o  (prod_vld),
    .tag_o  (prod_tag),
    .p_o    (prod)
  );

  // Collect products into the rotated center and the offset term tables.
  logic signed [ACC_W-1:0]  base_x_q, base_y_q;
  logic signed [TERM_W-1:0] tcos_q [TAPS];
  logic signed [TERM_W-1:0] tsin_q [TAPS];
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  dis_val;
  logic [ISSUE_W-1:0]       tag_off;
  logic [TAP_W-1:0]         tj;

  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign dis_val  = {{(ACC_W-SHIFT){1'b0}}, dis_q, {(SHIFT-1){1'b0}}};
  assign tag_off  = prod_tag - MUL_TERMS;
  assign tj       = tag_off[TAP_W:1];

  always_ff @(posedge clk_i) begin
    if (prod_vld) begin
      case (prod_tag)
        MUL_CX_COS: base_x_q <= prod_ext + dis_val;
        MUL_CY_SIN: base_x_q <= base_x_q + prod_ext;
        MUL_CY_COS: base_y_q <= prod_ext + dis_val;
        MUL_CX_SIN: base_y_q <= base_y_q - prod_ext;
        default: begin
          if (tag_off[0]) begin
            tsin_q[tj] <= prod[TERM_W-1:0];
          end else begin
            tcos_q[tj] <= prod[TERM_W-1:0];
          end
        end
      endcase
    end
  end

  // Term table read: row index while forming the row base, column index otherwise.
  logic [TAP_W-1:0]        rd_j;
  logic signed [ACC_W-1:0] tc_ext, ts_ext;

  assign rd_j   = (state_q == S_ROW) ? r_q : c_q;
  assign tc_ext = {{(ACC_W-TERM_W){tcos_q[rd_j][TERM_W-1]}}, tcos_q[rd_j]};
  assign ts_ext = {{(ACC_W-TERM_W){tsin_q[rd_j][TERM_W-1]}}, tsin_q[rd_j]};

  // Row base and rotated sample point.
  logic signed [ACC_W-1:0] rowb_x_q, rowb_y_q;
  logic signed [ACC_W-1:0] rx_q, ry_q;
  logic                    smp_vld_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_ROW) begin
      rowb_x_q <= base_x_q + ts_ext;
      rowb_y_q <= base_y_q + tc_ext;
    end
    if (state_q == S_SCAN) begin
      rx_q <= rowb_x_q + tc_ext;
      ry_q <= rowb_y_q - ts_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_vld_q <= 1'b0;
    end else begin
      smp_vld_q <= (state_q == S_SCAN);
    end
  end

  // Floor by dropping the fraction, then saturate to the cell range.
  cell_smp_t smp;

  always_comb begin
    smp.vld = smp_vld_q;
    smp.x   = sat_cell(rx_q[ACC_W-1:SHIFT]);
    smp.y   = sat_cell(ry_q[ACC_W-1:SHIFT]);
  end

  logic [CNT_W-1:0]         used;
  logic signed [CELL_W-1:0] rd_x, rd_y;
  logic [COUNT_W-1:0]       rd_cnt;

  rpcc_cell_table #(
    .CELL_SLOTS (CELL_SLOTS)
  ) u_cell_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (in_acc),
    .smp_i    (smp),
    .rd_idx_i (emit_idx_q[IDX_W-1:0]),
    .used_o   (used),
    .rd_x_o   (rd_x),
    .rd_y_o   (rd_y),
    .rd_cnt_o (rd_cnt)
  );

  assign emit_load = (state_q == S_EMIT) && (emit_idx_q != used) &&
                     (!out_valid_q || !out_stall_i);

  // Next state and counters.
  always_comb begin
    state_d    = state_q;
    mi_d       = mi_q;
    r_d        = r_q;
    c_d        = c_q;
    emit_idx_d = emit_idx_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          mi_d    = '0;
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        mi_d = mi_q + 1'b1;
        if (mi_q == last_issue) begin
          state_d = S_MWAIT;
        end
      end
      S_MWAIT: begin
        r_d     = '0;
        state_d = S_ROW;
      end
      S_ROW: begin
        c_d     = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (c_q == two_n) begin
          if (r_q == two_n) begin
            state_d = S_DRAIN;
          end else begin
            r_d     = r_q + 1'b1;
            state_d = S_ROW;
          end
        end else begin
          c_d = c_q + 1'b1;
        end
      end
      S_DRAIN: begin
        emit_idx_d = '0;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (emit_idx_q == used) begin
          state_d = S_IDLE;
        end else if (emit_load) begin
          emit_idx_d = emit_idx_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      mi_q       <= '0;
      r_q        <= '0;
      c_q        <= '0;
      emit_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      mi_q       <= mi_d;
      r_q        <= r_d;
      c_q        <= c_d;
      emit_idx_q <= emit_idx_d;
    end
  end

  // Output register: holds a cell until its transaction completes.
  logic signed [CELL_W-1:0] cell_x_q, cell_y_q;
  logic [COUNT_W-1:0]       count_q;
  logic                     last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      cell_x_q <= rd_x;
      cell_y_q <= rd_y;
      count_q  <= rd_cnt;
      last_q   <= (emit_idx_q == (used - 1'b1));
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cell_x_o       = cell_x_q;
  assign cell_y_o       = cell_y_q;
  assign sample_count_o = count_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire

[design/rpcc_mul.sv]
// Shared signed multiplier with a registered product and issue tag.
// Depends on rpcc_pkg.
`default_nettype none

module rpcc_mul
  import rpcc_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      vld_i,
  input  wire logic [ISSUE_W-1:0]        tag_i,
  input  wire logic signed [COORD_W-1:0] a_i,
  input  wire logic signed [TRIG_W-1:0]  b_i,
  output logic                           vld_o,
  output logic [ISSUE_W-1:0]             tag_o,
  output logic signed [PROD_W-1:0]       p_o
);

  logic                     vld_q;
  logic [ISSUE_W-1:0]       tag_q;
  logic signed [PROD_W-1:0] p_q;

  // Valid flag of the product register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  // Product and its tag.
  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      tag_q <= tag_i;
      p_q   <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  assign vld_o = vld_q;
  assign tag_o = tag_q;
  assign p_o   = p_q;

endmodule

`default_nettype wire

[design/rpcc_cell_table.sv]
// Table of distinct cells hit by the samples of one pixel, with a count each.
// Depends on rpcc_pkg.
`default_nettype none

module rpcc_cell_table
  import rpcc_pkg::*;
#(
  parameter int CELL_SLOTS = 9
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             clear_i,
  input  wire cell_smp_t                        smp_i,
  input  wire logic [$clog2(CELL_SLOTS)-1:0]    rd_idx_i,
  output logic [$clog2(CELL_SLOTS+1)-1:0]       used_o,
  output logic signed [CELL_W-1:0]              rd_x_o,
  output logic signed [CELL_W-1:0]              rd_y_o,
  output logic [COUNT_W-1:0]                    rd_cnt_o
);

  localparam int CNT_W = $clog2(CELL_SLOTS + 1);

  logic signed [CELL_W-1:0] x_q   [CELL_SLOTS];
  logic signed [CELL_W-1:0] y_q   [CELL_SLOTS];
  logic [COUNT_W-1:0]       cnt_q [CELL_SLOTS];
  logic [CNT_W-1:0]         used_q;
  logic [CELL_SLOTS-1:0]    hit;
  logic                     any_hit;
  logic                     append;

  // Compare the sample against every occupied slot at once.
  always_comb begin
    for (int k = 0; k < CELL_SLOTS; k++) begin
      hit[k] = (CNT_W'(k) < used_q) && (x_q[k] == smp_i.x) && (y_q[k] == smp_i.y);
    end
  end

  assign any_hit = |hit;
  assign append  = smp_i.vld && !any_hit && (used_q < CNT_W'(CELL_SLOTS));

  // Slot contents: bump a matching count or fill the next free slot.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < CELL_SLOTS; k++) begin
      if (smp_i.vld && hit[k]) begin
        if (cnt_q[k] != {COUNT_W{1'b1}}) begin
          cnt_q[k] <= cnt_q[k] + 1'b1;
        end
      end else if (append && (used_q == CNT_W'(k))) begin
        x_q[k]   <= smp_i.x;
        y_q[k]   <= smp_i.y;
        cnt_q[k] <= COUNT_W'(1);
      end
    end
  end

  // Number of occupied slots.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (clear_i) begin
      used_q <= '0;
    end else if (append) begin
      used_q <= used_q + 1'b1;
    end
  end

  assign used_o   = used_q;
  assign rd_x_o   = x_q[rd_idx_i];
  assign rd_y_o   = y_q[rd_idx_i];
  assign rd_cnt_o = cnt_q[rd_idx_i];

endmodule

`default_nettype wire

[tb/tb_rotated_pixel_cell_coverage.sv]
// Self-checking testbench for rotated_pixel_cell_coverage: directed table, then random phases.
// Depends on rpcc_pkg and the block's RTL; expected cells come from an in-bench predictor or typed table rows.
module tb_rotated_pixel_cell_coverage;
  import rpcc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SLOTS   = 9;
  localparam int CELL_LO       = -(1 << (CELL_W - 1));
  localparam int CELL_HI       = (1 << (CELL_W - 1)) - 1;
  localparam int TENTH_LIMIT   = 6553;   // largest fraction that is still below 0.1
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 300;
  localparam int LONG_HOLD     = 1500;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 45;
  localparam int ONE_Q16       = 65536;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W - 1){1'b0}}};
  localparam logic [TRIG_W-1:0] TRIG_MAX = {1'b0, {(TRIG_W - 1){1'b1}}};
  localparam logic [TRIG_W-1:0] TRIG_MIN = {1'b1, {(TRIG_W - 1){1'b0}}};

  typedef enum int {FLOW_FREE, FLOW_SEND_GAPS, FLOW_RECV_STALLS, FLOW_BOTH} flow_mode_e;
  typedef enum int {COORD_ANY, COORD_SMALL_FRAC, COORD_NEAR_TENTH, COORD_EDGE} coord_kind_e;

  // One covered cell as the block reports it.
  typedef struct packed {
    logic signed [CELL_W-1:0] x;
    logic signed [CELL_W-1:0] y;
    logic [COUNT_W-1:0]       hits;
    logic                     last;
  } cell_result_t;

  // One row of the directed table.
  typedef struct packed {
    logic                      reconfig;
    logic [TRIG_W-1:0]         radius_word;
    logic [TRIG_W-1:0]         cos_word;
    logic [TRIG_W-1:0]         sin_word;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic                      typed;
    cell_result_t              want;
  } directed_row_t;

  logic                      clk_i;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_idx_i   = REG_RADIUS;
  logic [TRIG_W-1:0]         cfg_data_i  = '0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  logic signed [COORD_W-1:0] center_x_i  = '0;
  logic signed [COORD_W-1:0] center_y_i  = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [CELL_W-1:0]  cell_x_o;
  logic signed [CELL_W-1:0]  cell_y_o;
  logic [COUNT_W-1:0]        sample_count_o;
  logic                      last_o;

  // Predictor copy of the configuration registers, starting from reset values.
  logic [RAD_W-1:0]         cur_radius = 3'd2;
  logic signed [TRIG_W-1:0] cur_cos    = TRIG_W'(ONE_Q16);
  logic signed [TRIG_W-1:0] cur_sin    = '0;

  cell_result_t  expected_cells[$];
  directed_row_t directed_rows[$];
  cell_result_t  got_cell;
  cell_result_t  want_cell;

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  long_hold_req  = 1'b0;
  bit  long_hold_done = 1'b0;
  int  long_hold_left = 0;
  int  mismatches     = 0;
  int  cells_checked  = 0;
  int  centers_sent   = 0;
  int  settings_used  = 0;
  int  full_tables    = 0;
  int  edge_cells     = 0;

  rotated_pixel_cell_coverage i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .center_x_i     (center_x_i),
    .center_y_i     (center_y_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cell_x_o       (cell_x_o),
    .cell_y_o       (cell_y_o),
    .sample_count_o (sample_count_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Appends one expected cell behind those already pending.
  task automatic append_cell(input cell_result_t c);
    expected_cells.insert(expected_cells.size(), c);
  endtask

  // Signed offset of sample tap j from the center, edge taps pulled in by one LSB.
  function automatic longint tap_offset(input int j, input int n);
    longint mag;
    mag = (longint'(j < 0 ? -j : j) << FRAC_BITS) / (2 * n);
    if (j < 0) mag = -mag;
    if (j == -n) mag = mag + 1;
    if (j == n) mag = mag - 1;
    return mag;
  endfunction

  // Floor of a rotated coordinate to its cell, clamped to the cell range.
  function automatic int cell_of(input longint v);
    longint q;
    q = v >>> SHIFT;
    if (q < CELL_LO) q = CELL_LO;
    if (q > CELL_HI) q = CELL_HI;
    return int'(q);
  endfunction

  // Scans the sample grid of one pixel and queues the cells it covers, in first-seen order.
  task automatic predict_coverage(input logic signed [COORD_W-1:0] cx,
                                  input logic signed [COORD_W-1:0] cy);
    int           n;
    int           used;
    int           gx;
    int           gy;
    bit           found;
    bit           dropped;
    longint       bias;
    longint       px;
    longint       py;
    longint       cosv;
    longint       sinv;
    int           slot_x[TABLE_SLOTS];
    int           slot_y[TABLE_SLOTS];
    int           slot_hits[TABLE_SLOTS];
    cell_result_t res;
    n = (cur_radius == 0) ? 1 : int'(cur_radius);
    cosv = longint'(cur_cos);
    sinv = longint'(cur_sin);
    bias = 0;
    if (int'(cx[FRAC_BITS-1:0]) * 10 < (1 << FRAC_BITS) &&
        int'(cy[FRAC_BITS-1:0]) * 10 < (1 << FRAC_BITS))
      bias = longint'(1) << (SHIFT - 1);
    used = 0;
    dropped = 1'b0;
    for (int row = -n; row <= n; row++) begin
      py = longint'(cy) + tap_offset(row, n);
      for (int col = -n; col <= n; col++) begin
        px = longint'(cx) + tap_offset(col, n);
        gx = cell_of(px * cosv + py * sinv + bias);
        gy = cell_of(py * cosv - px * sinv + bias);
        found = 1'b0;
        for (int k = 0; k < used; k++) begin
          if (!found && slot_x[k] == gx && slot_y[k] == gy) begin
            slot_hits[k]++;
            found = 1'b1;
          end
        end
        // A new cell is dropped once the table is full.
        if (!found) begin
          if (used < TABLE_SLOTS) begin
            slot_x[used] = gx;
            slot_y[used] = gy;
            slot_hits[used] = 1;
            used++;
          end else begin
            dropped = 1'b1;
          end
        end
      end
    end
    if (dropped) full_tables++;
    for (int k = 0; k < used; k++) begin
      res.x = slot_x[k][CELL_W-1:0];
      res.y = slot_y[k][CELL_W-1:0];
      res.hits = (slot_hits[k] > 255) ? 8'd255 : slot_hits[k][COUNT_W-1:0];
      res.last = (k == used - 1);
      if (slot_x[k] == CELL_LO || slot_x[k] == CELL_HI ||
          slot_y[k] == CELL_LO || slot_y[k] == CELL_HI)
        edge_cells++;
      append_cell(res);
    end
  endtask

  function automatic logic signed [COORD_W-1:0] random_coord(input coord_kind_e kind);
    logic signed [COORD_W-1:0] v;
    v = COORD_W'($urandom());
    case (kind)
      COORD_SMALL_FRAC: v[FRAC_BITS-1:0] = FRAC_BITS'($urandom_range(0, TENTH_LIMIT));
      COORD_NEAR_TENTH: begin
        v[FRAC_BITS-1:0] = FRAC_BITS'($urandom_range(TENTH_LIMIT - 3, TENTH_LIMIT + 7));
      end
      COORD_EDGE: begin
        if ($urandom_range(0, 1) != 0) v = COORD_MAX - COORD_W'($urandom_range(0, 200000));
        else v = COORD_MIN + COORD_W'($urandom_range(0, 200000));
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic add_row(input logic reconfig, input logic [TRIG_W-1:0] radius_word,
                         input logic [TRIG_W-1:0] cos_word, input logic [TRIG_W-1:0] sin_word,
                         input logic signed [COORD_W-1:0] cx,
                         input logic signed [COORD_W-1:0] cy,
                         input logic typed, input int wx, input int wy, input int whits);
    directed_row_t row;
    row.reconfig = reconfig;
    row.radius_word = radius_word;
    row.cos_word = cos_word;
    row.sin_word = sin_word;
    row.cx = cx;
    row.cy = cy;
    row.typed = typed;
    row.want.x = wx[CELL_W-1:0];
    row.want.y = wy[CELL_W-1:0];
    row.want.hits = whits[COUNT_W-1:0];
    row.want.last = 1'b1;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Writes all three registers, then a write to the unused index that must change nothing.
  task automatic write_settings(input logic [TRIG_W-1:0] radius_word,
                                input logic [TRIG_W-1:0] cos_word,
                                input logic [TRIG_W-1:0] sin_word);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_RADIUS;
    cfg_data_i <= radius_word;
    @(posedge clk_i);
    cfg_idx_i  <= REG_COS;
    cfg_data_i <= cos_word;
    @(posedge clk_i);
    cfg_idx_i  <= REG_SIN;
    cfg_data_i <= sin_word;
    @(posedge clk_i);
    cfg_idx_i  <= REG_UNUSED;
    cfg_data_i <= TRIG_W'($urandom());
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_radius = radius_word[RAD_W-1:0];
    cur_cos    = cos_word;
    cur_sin    = sin_word;
    settings_used++;
  endtask

  // Offers one pixel center and queues its cells once the transaction is taken.
  task automatic offer_center(input logic signed [COORD_W-1:0] cx,
                              input logic signed [COORD_W-1:0] cy,
                              input logic typed, input cell_result_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    center_x_i <= cx;
    center_y_i <= cy;
    do @(posedge clk_i); while (in_stall_o);
    if (typed) append_cell(want);
    else predict_coverage(cx, cy);
    centers_sent++;
  endtask

  // Lets every queued cell come out and the block fall idle.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_cell = '{x: cell_x_o, y: cell_y_o, hits: sample_count_o, last: last_o};
      if (expected_cells.size() == 0) begin
        $error("cell (%0d, %0d) count %0d arrived with nothing pending",
               cell_x_o, cell_y_o, sample_count_o);
        mismatches++;
      end else begin
        want_cell = expected_cells.pop_front();
        cells_checked++;
        if (got_cell.x !== want_cell.x) begin
          $error("cell_x: expected %0d, got %0d", want_cell.x, got_cell.x);
          mismatches++;
        end
        if (got_cell.y !== want_cell.y) begin
          $error("cell_y: expected %0d, got %0d", want_cell.y, got_cell.y);
          mismatches++;
        end
        if (got_cell.hits !== want_cell.hits) begin
          $error("sample_count: expected %0d, got %0d", want_cell.hits, got_cell.hits);
          mismatches++;
        end
        if (got_cell.last !== want_cell.last) begin
          $error("last: expected %0b, got %0b", want_cell.last, got_cell.last);
          mismatches++;
        end
      end
    end
  end

  // Receiver stall driver; one long hold-off lets the block fill up and push back on its input.
  always @(posedge clk_i) begin
    if (long_hold_req && !long_hold_done) begin
      long_hold_left = LONG_HOLD;
      long_hold_done = 1'b1;
    end
    if (long_hold_left > 0) begin
      long_hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Run limit, far above the slowest passing run.
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [TRIG_W-1:0]         radius_word;
    logic [TRIG_W-1:0]         cos_word;
    logic [TRIG_W-1:0]         sin_word;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    int                        pick;
    int                        directed_count;
    real                       theta;
    flow_mode_e                mode;
    cell_result_t              no_cell;

    no_cell = '0;

    // Reset settings first: centered pixel, bias case, the 0.1 threshold and the corners.
    add_row(0, 0, 0, 0, 32768, 32768, 1, 0, 0, 25);
    add_row(0, 0, 0, 0, 0, 0, 1, 0, 0, 25);
    add_row(0, 0, 0, 0, TENTH_LIMIT, TENTH_LIMIT, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, TENTH_LIMIT + 1, TENTH_LIMIT, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, TENTH_LIMIT, TENTH_LIMIT + 1, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, COORD_MAX, COORD_MAX, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, COORD_MIN, COORD_MIN, 0, 0, 0, 0);
    // Radius zero counts as one; radius seven gives the full grid, upper data bits ignored.
    add_row(1, 0, ONE_Q16, 0, 32768, 32768, 1, 0, 0, 9);
    add_row(1, 18'h3FFFF, ONE_Q16, 0, 360448, -229376, 1, 5, -4, 225);
    // Quarter and half turns, then an eighth turn.
    add_row(1, 2, 0, ONE_Q16, 32768, 32768, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 100000, -50000, 0, 0, 0, 0);
    add_row(1, 2, -ONE_Q16, 0, 32768, 32768, 1, -1, -1, 25);
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(1, 3, 46341, 46341, 32768, 32768, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // Off-range trig values: clamped cells and an overfull cell table.
    add_row(1, 2, TRIG_MAX, TRIG_MIN, COORD_MAX, COORD_MAX, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, COORD_MIN, COORD_MIN, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, COORD_MAX, COORD_MIN, 0, 0, 0, 0);
    add_row(1, 7, TRIG_MAX, TRIG_MIN, 12345, 54321, 0, 0, 0, 0);
    add_row(1, 0, TRIG_MIN, TRIG_MAX, COORD_MAX, COORD_MIN, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, COORD_MIN, COORD_MAX, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, TENTH_LIMIT, 0, 0, 0, 0, 0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].reconfig) begin
        drain_block();
        write_settings(directed_rows[i].radius_word, directed_rows[i].cos_word,
                       directed_rows[i].sin_word);
      end
      offer_center(directed_rows[i].cx, directed_rows[i].cy, directed_rows[i].typed,
                   directed_rows[i].want);
    end
    directed_count = centers_sent;
    drain_block();

    // Random phases, each with its own settings and flow-control mode.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          radius_word = 7;
          cos_word = TRIG_MAX;
          sin_word = TRIG_MIN;
        end
        1: begin
          radius_word = 0;
          cos_word = TRIG_MIN;
          sin_word = TRIG_MAX;
        end
        default: begin
          radius_word = TRIG_W'($urandom());
          if ($urandom_range(0, 3) != 0) begin
            theta = $urandom_range(0, 35999) * 3.14159265358979 / 18000.0;
            cos_word = TRIG_W'($rtoi($cos(theta) * ONE_Q16));
            sin_word = TRIG_W'($rtoi($sin(theta) * ONE_Q16));
          end else begin
            cos_word = TRIG_W'($urandom());
            sin_word = TRIG_W'($urandom());
          end
        end
      endcase
      write_settings(radius_word, cos_word, sin_word);

      mode = flow_mode_e'(phase % 4);
      case (mode)
        FLOW_SEND_GAPS: begin
          send_idle_pct = 49;
          recv_stall_pct = 0;
        end
        FLOW_RECV_STALLS: begin
          send_idle_pct = 0;
          recv_stall_pct = 49;
        end
        FLOW_BOTH: begin
          send_idle_pct = 22;
          recv_stall_pct = 22;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      if (phase == 4) long_hold_req = 1'b1;

      for (int item = 0; item < PHASE_ITEMS; item++) begin
        pick = $urandom_range(0, 9);
        if (pick <= 3) begin
          cx = random_coord(COORD_ANY);
          cy = random_coord(COORD_ANY);
        end else if (pick <= 6) begin
          cx = random_coord(COORD_SMALL_FRAC);
          cy = random_coord(COORD_SMALL_FRAC);
        end else if (pick == 7) begin
          cx = random_coord(COORD_NEAR_TENTH);
          cy = random_coord(COORD_SMALL_FRAC);
        end else if (pick == 8) begin
          cx = random_coord(COORD_SMALL_FRAC);
          cy = random_coord(COORD_NEAR_TENTH);
        end else begin
          cx = random_coord(COORD_EDGE);
          cy = random_coord(COORD_EDGE);
        end
        offer_center(cx, cy, 1'b0, no_cell);
      end
      drain_block();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d pixel centers (%0d from the directed table) under %0d register settings.",
             centers_sent, directed_count, settings_used);
    $display("Compared %0d cells; %0d items overflowed the cell table, %0d cells hit the range.",
             cells_checked, full_tables, edge_cells);
    if (mismatches == 0 && expected_cells.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[rotated_pixel_cell_coverage.f]
design/rpcc_pkg.sv
design/rpcc_mul.sv
design/rpcc_cell_table.sv
design/rotated_pixel_cell_coverage.sv
tb/tb_rotated_pixel_cell_coverage.sv
